/* rtl/pyuv_pkg.sv */
// Package: shared types and constants of the packed 4:1:1 to RGB converter.
`default_nettype none
package pyuv_pkg;

	// Group geometry
	localparam int unsigned LANES   = 4;
	localparam int unsigned CNT_W   = $clog2(LANES + 1);
	localparam int unsigned SKIP_N  = 2;

	// Fixed-point format
	localparam int unsigned FRAC_BITS = 12;
	localparam int unsigned TERM_W    = 23;
	localparam int unsigned SUM_W     = 24;

	localparam logic signed [14:0] COEF_V_R = 15'sd5743;
	localparam logic signed [14:0] COEF_U_G = 15'sd1411;
	localparam logic signed [14:0] COEF_V_G = 15'sd2925;
	localparam logic signed [14:0] COEF_U_B = 15'sd7258;
	localparam logic signed [SUM_W-1:0] ROUND_HALF = 24'sd2048;

	// Register map (word index)
	localparam logic REG_SKIP_MODE = 1'b0;

	// Chroma contributions shared by all lanes of a group
	typedef struct packed {
		logic signed [TERM_W-1:0] red_term;
		logic signed [TERM_W-1:0] green_term;
		logic signed [TERM_W-1:0] blue_term;
	} chroma_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

endpackage
`default_nettype wire

/* rtl/packed_yuv411_to_rgb_core.sv */
// Top level: packed 4:1:1 group to RGB pixel stream converter.
//
//  channel  direction  handshake             payload
//  in       request    in_valid / in_ready   chroma_u, luma_0, chroma_v, luma_1..3
//  out      result     out_valid / out_ready red, green, blue, last_of_group
//  cfg      APB write  psel/penable/pwrite   skip_mode at word 0
//
// A group is registered with its chroma products at the accepting edge; the
// four lanes convert it combinationally, and it is loaded into the merge buffer
// when that buffer is empty or its last pixel leaves; the buffer then offers it.
// The merge stage emits one pixel per cycle while out_ready is high: four per
// group (two in skip mode), and the next group loads as the last pixel leaves.
// A stalled output holds the buffer; one further group waits in stage 1.
// Asynchronous active-low reset empties both stages and clears skip_mode.
`default_nettype none
module packed_yuv411_to_rgb_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// Request channel
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic signed [7:0] chroma_u,
	input  wire logic [7:0]        luma_0,
	input  wire logic signed [7:0] chroma_v,
	input  wire logic [7:0]        luma_1,
	input  wire logic [7:0]        luma_2,
	input  wire logic [7:0]        luma_3,
	// Result channel
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [7:0]             red,
	output logic [7:0]             green,
	output logic [7:0]             blue,
	output logic                   last_of_group,
	// Configuration port
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	logic                  skip_q;
	logic                  in_take;
	logic                  load;
	pyuv_pkg::chroma_t     terms;
	pyuv_pkg::chroma_t     terms_s1;
	logic [7:0]            luma_s1 [pyuv_pkg::LANES];
	logic                  valid_s1;
	logic                  skip_s1;
	pyuv_pkg::pixel_t      lane_pix [pyuv_pkg::LANES];
	pyuv_pkg::pixel_t      out_pix;

	// Configuration register
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= 1'b0;
		end else if (psel && penable && pwrite && pready
				&& (paddr[2] == pyuv_pkg::REG_SKIP_MODE)) begin
			skip_q <= pwdata[0];
		end
	end
	assign prdata = (paddr[2] == pyuv_pkg::REG_SKIP_MODE) ? {31'd0, skip_q} : 32'd0;

	// Shared chroma products
	pyuv_chroma u_chroma (
		.chroma_u (chroma_u),
		.chroma_v (chroma_v),
		.terms    (terms)
	);

	// Stage 1: group with its products
	assign in_ready = !valid_s1 || load;
	assign in_take  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			terms_s1   <= terms;
			luma_s1[0] <= luma_0;
			luma_s1[1] <= luma_1;
			luma_s1[2] <= luma_2;
			luma_s1[3] <= luma_3;
			skip_s1    <= skip_q;
		end
	end

	// Conversion lanes
	for (genvar g = 0; g < pyuv_pkg::LANES; g++) begin : g_lane
		pyuv_lane u_lane (
			.luma  (luma_s1[g]),
			.terms (terms_s1),
			.pixel (lane_pix[g])
		);
	end

	// Merge and play-out
	pyuv_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp_valid (valid_s1),
		.grp_skip  (skip_s1),
		.lane_pix  (lane_pix),
		.load      (load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_pix   (out_pix),
		.out_last  (last_of_group)
	);

	assign red   = out_pix.red;
	assign green = out_pix.green;
	assign blue  = out_pix.blue;

	// Checks
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid)
		else $error("loaded group not presented");

	a_take_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> valid_s1)
		else $error("accepted request lost before stage 1");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !load) |=> (valid_s1 && $stable(terms_s1) && $stable(skip_s1)))
		else $error("stage 1 changed while waiting");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_of_group && !load) |=> !out_valid)
		else $error("pixel after last of group");

	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!out_valid || (last_of_group && out_ready)))
		else $error("group loaded over pending pixels");

endmodule
`default_nettype wire

/* rtl/pyuv_chroma.sv */
// Shared chroma multipliers: one product set per group, used by every lane.
`default_nettype none
module pyuv_chroma (
	input  wire logic signed [7:0] chroma_u,
	input  wire logic signed [7:0] chroma_v,
	output pyuv_pkg::chroma_t      terms
);

	logic signed [pyuv_pkg::TERM_W-1:0] u_g;
	logic signed [pyuv_pkg::TERM_W-1:0] v_g;

	// Green takes both chroma parts, subtracted
	assign u_g = chroma_u * pyuv_pkg::COEF_U_G;
	assign v_g = chroma_v * pyuv_pkg::COEF_V_G;

	assign terms.red_term   = chroma_v * pyuv_pkg::COEF_V_R;
	assign terms.green_term = -u_g - v_g;
	assign terms.blue_term  = chroma_u * pyuv_pkg::COEF_U_B;

endmodule
`default_nettype wire

/* rtl/pyuv_lane.sv */
// One conversion lane: luma plus shared chroma terms, rounding, shift, clip.
`default_nettype none
module pyuv_lane (
	input  wire logic [7:0]         luma,
	input  wire pyuv_pkg::chroma_t  terms,
	output pyuv_pkg::pixel_t        pixel
);

	logic signed [pyuv_pkg::SUM_W-1:0] luma_fx;
	logic signed [pyuv_pkg::SUM_W-1:0] sum_r;
	logic signed [pyuv_pkg::SUM_W-1:0] sum_g;
	logic signed [pyuv_pkg::SUM_W-1:0] sum_b;

	// Floor shift by the fraction bits, then limit to 0..255
	function automatic logic [7:0] clip8(input logic signed [pyuv_pkg::SUM_W-1:0] s);
		logic [7:0] r;
		if (s[pyuv_pkg::SUM_W-1]) begin
			r = 8'd0;
		end else if (|s[pyuv_pkg::SUM_W-2:pyuv_pkg::FRAC_BITS+8]) begin
			r = 8'd255;
		end else begin
			r = s[pyuv_pkg::FRAC_BITS+7:pyuv_pkg::FRAC_BITS];
		end
		return r;
	endfunction

	assign luma_fx = $signed({{(pyuv_pkg::SUM_W-8-pyuv_pkg::FRAC_BITS){1'b0}}, luma,
		{pyuv_pkg::FRAC_BITS{1'b0}}});

	assign sum_r = luma_fx + pyuv_pkg::SUM_W'(terms.red_term) + pyuv_pkg::ROUND_HALF;
	assign sum_g = luma_fx + pyuv_pkg::SUM_W'(terms.green_term) + pyuv_pkg::ROUND_HALF;
	assign sum_b = luma_fx + pyuv_pkg::SUM_W'(terms.blue_term) + pyuv_pkg::ROUND_HALF;

	assign pixel.red   = clip8(sum_r);
	assign pixel.green = clip8(sum_g);
	assign pixel.blue  = clip8(sum_b);

endmodule
`default_nettype wire

/* rtl/pyuv_merge.sv */
// Merge stage: captures all lane results of a group and plays them out in order.
`default_nettype none
module pyuv_merge (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                grp_valid,
	input  wire logic                grp_skip,
	input  wire pyuv_pkg::pixel_t    lane_pix [pyuv_pkg::LANES],
	output logic                     load,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output pyuv_pkg::pixel_t         out_pix,
	output logic                     out_last
);

	pyuv_pkg::pixel_t                pix_q [pyuv_pkg::LANES];
	logic [pyuv_pkg::CNT_W-1:0]      rem_q;
	logic                            take;

	assign out_valid = (rem_q != '0);
	assign take      = out_valid && out_ready;
	assign out_last  = (rem_q == pyuv_pkg::CNT_W'(1));
	assign out_pix   = pix_q[0];

	// Refill when empty or when the final pixel leaves this cycle
	assign load = grp_valid && (!out_valid || (out_last && out_ready));

	// Remaining-pixel count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= grp_skip ? pyuv_pkg::CNT_W'(pyuv_pkg::SKIP_N)
				: pyuv_pkg::CNT_W'(pyuv_pkg::LANES);
		end else if (take) begin
			rem_q <= rem_q - pyuv_pkg::CNT_W'(1);
		end
	end

	// Pixel shift line, head at entry 0
	always_ff @(posedge clk) begin
		if (load) begin
			pix_q <= lane_pix;
		end else if (take) begin
			for (int i = 0; i < pyuv_pkg::LANES - 1; i++) begin
				pix_q[i] <= pix_q[i+1];
			end
		end
	end

endmodule
`default_nettype wire
